// File: rtl/double_hash_key_set_top_assert.svh
// assertion macros for the double hash key set
`ifndef DOUBLE_HASH_KEY_SET_TOP_ASSERT_SVH
`define DOUBLE_HASH_KEY_SET_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DHKS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DHKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dhks_pkg.sv
// shared types and constants of the double hash key set
package dhks_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int EFF_W       = ADDR_W + 1;
    localparam int CFG_W       = 13;
    localparam int KEY_W       = 31;
    localparam int SLOT_W      = 12;
    localparam int BIT_W       = $clog2(KEY_W);
    localparam int STEP_MOD    = 11;
    localparam int STEP_W      = $clog2(STEP_MOD);
    localparam int FOLD_W      = 8;
    localparam int FOLD_BIAS   = 9 * STEP_MOD;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(4093);

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic              status;
    } t_out_item;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_slot_word;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              clr_start;
        logic [ADDR_W-1:0] addr;
        t_slot_word        wdata;
    } t_store_req;

    typedef struct packed {
        logic       clr_busy;
        t_slot_word rd_data;
    } t_store_rsp;

    // configured size clamped to 1 .. TABLE_DEPTH
    function automatic logic [EFF_W-1:0] eff_size(input logic [CFG_W-1:0] cfg);
        logic [CFG_W+EFF_W-1:0] wide;
        wide = (CFG_W+EFF_W)'(cfg);
        if (cfg == '0) begin
            return EFF_W'(1);
        end
        if (wide > (CFG_W+EFF_W)'(TABLE_DEPTH)) begin
            return EFF_W'(TABLE_DEPTH);
        end
        return EFF_W'(wide);
    endfunction

    // 5-bit digits alternate in sign mod 11 since 32 is -1 mod 11, bias keeps it positive
    function automatic logic [FOLD_W-1:0] fold11(input logic [KEY_W-1:0] key);
        logic [FOLD_W-1:0] pos_sum;
        logic [FOLD_W-1:0] neg_sum;
        pos_sum = FOLD_W'(key[4:0]) + FOLD_W'(key[14:10]) + FOLD_W'(key[24:20])
                + FOLD_W'(key[30]);
        neg_sum = FOLD_W'(key[9:5]) + FOLD_W'(key[19:15]) + FOLD_W'(key[29:25]);
        return pos_sum + FOLD_W'(FOLD_BIAS) - neg_sum;
    endfunction

    // folded value brought below 11 by compare and subtract of 176, 88, 44, 22, 11
    function automatic logic [STEP_W-1:0] reduce11(input logic [FOLD_W-1:0] fold);
        logic [FOLD_W-1:0] v;
        v = fold;
        for (int i = 4; i >= 0; i--) begin
            if (v >= FOLD_W'(STEP_MOD << i)) begin
                v = v - FOLD_W'(STEP_MOD << i);
            end
        end
        return STEP_W'(v);
    endfunction

endpackage

// File: rtl/dhks_store.sv
// slot memory with a clearing sweep after reset and on request
module dhks_store import dhks_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_req i_req,
    output t_store_rsp o_rsp
);

    t_slot_word        r_mem [TABLE_DEPTH];
    t_slot_word        r_rd_data;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (i_req.clr_start) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // sweep owns the write port while it runs
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rsp.clr_busy = r_clr_busy;
    assign o_rsp.rd_data  = r_rd_data;

endmodule

// File: rtl/double_hash_key_set_top.sv
// double hash key set: 4096 slots, one shared compare-subtract unit, registered result
// insert/lookup: accept, bitwise remainder of the key by the size, step reduction, a read and a check
//   per probe, then the result register; one item at a time
// clear: the store sweeps every slot, one slot per cycle through the memory write port
// reset (synchronous, active low) starts a clearing pass over all 4096 slots; no transfer is taken
//   until it ends; table_size resets to 4093
module double_hash_key_set_top import dhks_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

`include "double_hash_key_set_top_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_STEP,
        S_READ,
        S_CHECK,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cfg, n_cfg;
    logic [EFF_W-1:0]   r_size, n_size;
    logic [1:0]         r_cmd, n_cmd;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [EFF_W-1:0]   r_rem, n_rem;
    logic [FOLD_W-1:0]  r_fold, n_fold;
    logic [STEP_W-1:0]  r_rem11, n_rem11;
    logic [EFF_W-1:0]   r_step, n_step;
    logic [EFF_W-1:0]   r_probe, n_probe;
    t_out_item          r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    t_store_req         w_req;
    t_store_rsp         w_rsp;

    // shared compare-subtract unit against the table size
    logic [EFF_W:0]     u_a;
    logic               u_ge;
    logic [EFF_W:0]     u_y;

    logic [STEP_W-1:0]  w_r11;
    logic               w_in_xfer;
    logic               w_out_free;
    logic               w_hit;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_hit      = w_rsp.rd_data.valid && (w_rsp.rd_data.key == r_key);

    always_comb begin
        case (r_state)
            S_DIV:   u_a = {r_rem, r_key[r_bit]};
            S_STEP:  u_a = (EFF_W+1)'(r_step);
            S_CHECK: u_a = (EFF_W+1)'(r_rem) + (EFF_W+1)'(r_step);
            default: u_a = '0;
        endcase
        u_ge = u_a >= {1'b0, r_size};
        u_y  = u_ge ? (u_a - {1'b0, r_size}) : u_a;
    end

    // key mod 11 from the folded key, registered before the step is formed
    assign w_r11 = reduce11(r_fold);

    always_comb begin
        n_state     = r_state;
        n_cfg       = r_cfg;
        n_size      = r_size;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_bit       = r_bit;
        n_rem       = r_rem;
        n_fold      = r_fold;
        n_rem11     = r_rem11;
        n_step      = r_step;
        n_probe     = r_probe;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        w_req           = '0;
        w_req.addr      = ADDR_W'(r_rem);
        w_req.wdata     = '{valid: 1'b1, key: r_key};

        if (i_cfg_wr_en) begin
            n_cfg = i_cfg_wr_data;
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_cmd   = i_in_data.command;
                    n_key   = i_in_data.key;
                    n_size  = eff_size(r_cfg);
                    n_bit   = BIT_W'(KEY_W - 1);
                    n_rem   = '0;
                    n_fold  = fold11(i_in_data.key);
                    n_rem11 = '0;
                    n_res   = '{found: 1'b0, slot: '0, status: STATUS_OK};
                    if (i_in_data.command == CMD_CLEAR) begin
                        w_req.clr_start = 1'b1;
                        n_state         = S_CLEAR;
                    end else if (i_in_data.command == CMD_INSERT ||
                                 i_in_data.command == CMD_LOOKUP) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                n_rem   = EFF_W'(u_y);
                n_rem11 = w_r11;
                n_bit   = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_step  = EFF_W'(r_rem11) + 1'b1;
                    n_probe = '0;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                // bring the step below the size, matters for tiny sizes only
                if (u_ge) begin
                    n_step = EFF_W'(u_y);
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                w_req.rd_en = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if (!w_rsp.rd_data.valid || w_hit) begin
                    n_res.found  = w_hit;
                    n_res.slot   = SLOT_W'(r_rem);
                    n_res.status = STATUS_OK;
                    w_req.wr_en  = !w_rsp.rd_data.valid && (r_cmd == CMD_INSERT);
                    n_state      = S_DONE;
                end else if (EFF_W'(r_probe + 1'b1) == r_size) begin
                    n_res.status = STATUS_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_rem   = EFF_W'(u_y);
                    n_probe = r_probe + 1'b1;
                    n_state = S_READ;
                end
            end
            S_CLEAR: begin
                if (!w_rsp.clr_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
        r_size  <= n_size;
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_bit   <= n_bit;
        r_rem   <= n_rem;
        r_fold  <= n_fold;
        r_rem11 <= n_rem11;
        r_step  <= n_step;
        r_probe <= n_probe;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    dhks_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE) || w_rsp.clr_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `DHKS_ASSERT_NOW(a_write_only_on_empty_insert, w_req.wr_en, (r_state == S_CHECK) && (r_cmd == CMD_INSERT) && !w_rsp.rd_data.valid, "slot write outside an insert into an empty slot")
    `DHKS_ASSERT_NOW(a_full_result_shape, o_out_valid && (o_out_data.status == STATUS_FULL), !o_out_data.found && (o_out_data.slot == '0), "full result carries found or slot")
    `DHKS_ASSERT_NOW(a_probe_bound, (r_state == S_READ) || (r_state == S_CHECK), (r_probe < r_size) && (r_rem < r_size) && (r_step < r_size), "probe walk left the table")
    `DHKS_ASSERT_NEXT(a_result_from_done, !r_out_valid || !i_out_stall, (r_out_valid == $past(r_state == S_DONE)), "result register loaded outside the done state")

endmodule

// File: sim/tb_double_hash_key_set_top.sv
// testbench for double_hash_key_set_top: directed table, then random size phases checked against a shadow set
module tb_double_hash_key_set_top;
    import dhks_pkg::*;

    localparam int          RANDOM_ITEMS = 1300;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam int          MAX_PRINTED  = 100;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [30:0] KEY_TOP      = 31'h7FFF_FFFF;

    typedef enum logic {ROW_ITEM, ROW_SIZE} t_row_kind;

    // a size row carries the new table_size in value; typed rows carry their own result
    typedef struct packed {
        t_row_kind         kind;
        logic [1:0]        command;
        logic [KEY_W-1:0]  value;
        logic              typed;
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic              status;
    } t_row;

    typedef struct {
        int unsigned seq;
        t_out_item   res;
    } t_pending;

    localparam t_row DIRECTED [24] = '{
        '{ROW_ITEM, CMD_LOOKUP, 31'd0,    1'b1, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_INSERT, 31'd0,    1'b1, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_INSERT, 31'd0,    1'b1, 1'b1, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_LOOKUP, 31'd0,    1'b1, 1'b1, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_INSERT, KEY_TOP,  1'b0, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_LOOKUP, KEY_TOP,  1'b0, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_INSERT, 31'd4093, 1'b0, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_LOOKUP, 31'd4093, 1'b0, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_UNUSED, KEY_TOP,  1'b1, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_CLEAR,  31'd0,    1'b1, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_LOOKUP, 31'd0,    1'b1, 1'b0, 12'd0,    STATUS_OK},
        // size zero behaves as a single slot
        '{ROW_SIZE, CMD_CLEAR,  31'd0,    1'b0, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_INSERT, 31'd5,    1'b1, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_INSERT, 31'd7,    1'b1, 1'b0, 12'd0,    STATUS_FULL},
        '{ROW_ITEM, CMD_LOOKUP, 31'd5,    1'b1, 1'b1, 12'd0,    STATUS_OK},
        // stored keys stay put when the size grows
        '{ROW_SIZE, CMD_CLEAR,  31'd13,   1'b0, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_INSERT, 31'd13,   1'b0, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_LOOKUP, 31'd5,    1'b0, 1'b0, 12'd0,    STATUS_OK},
        // oversized setting clamps to the full depth
        '{ROW_SIZE, CMD_CLEAR,  31'd8191, 1'b0, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_LOOKUP, KEY_TOP,  1'b1, 1'b0, 12'd4095, STATUS_OK},
        '{ROW_ITEM, CMD_INSERT, KEY_TOP,  1'b1, 1'b0, 12'd4095, STATUS_OK},
        // non-prime size
        '{ROW_SIZE, CMD_CLEAR,  31'd12,   1'b0, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_INSERT, 31'd24,   1'b0, 1'b0, 12'd0,    STATUS_OK},
        '{ROW_ITEM, CMD_CLEAR,  31'd0,    1'b1, 1'b0, 12'd0,    STATUS_OK}
    };

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] i_cfg_wr_data = '0;
    logic             i_in_valid    = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_data     = '0;
    logic             o_out_valid;
    logic             i_out_stall   = 1'b0;
    t_out_item        o_out_data;

    // shadow copy of the set
    bit               shadow_valid [TABLE_DEPTH];
    logic [KEY_W-1:0] shadow_key   [TABLE_DEPTH];
    logic [CFG_W-1:0] shadow_size = SIZE_RESET;

    t_pending         result_q [$];
    logic [KEY_W-1:0] key_pool [$];
    bit               calm;
    int unsigned      cycle_count = 0;
    int unsigned      error_count = 0;
    int unsigned      items_sent  = 0;
    int unsigned      n_results, n_insert, n_lookup, n_clear, n_other, n_hit, n_full, n_sizes;

    double_hash_key_set_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int unsigned usable_size(input logic [CFG_W-1:0] cfg);
        int unsigned s;
        s = cfg;
        if (s == 0) begin
            s = 1;
        end
        if (s > TABLE_DEPTH) begin
            s = TABLE_DEPTH;
        end
        return s;
    endfunction

    // applies one item to the shadow set and returns the result it should give
    function automatic t_out_item hash_set_predict(input t_in_item item);
        t_out_item   res;
        int unsigned size, pos, step, probes;
        bit          hit, hole;
        res = '0;
        if (item.command == CMD_CLEAR) begin
            foreach (shadow_valid[i]) begin
                shadow_valid[i] = 1'b0;
            end
        end else if (item.command == CMD_INSERT || item.command == CMD_LOOKUP) begin
            size   = usable_size(shadow_size);
            pos    = item.key % size;
            step   = 1 + (item.key % STEP_MOD);
            hit    = 1'b0;
            hole   = 1'b0;
            probes = 0;
            while (!hit && !hole && probes < size) begin
                if (!shadow_valid[pos]) begin
                    hole = 1'b1;
                end else if (shadow_key[pos] == item.key) begin
                    hit = 1'b1;
                end else begin
                    pos = (pos + step) % size;
                    probes++;
                end
            end
            if (hit || hole) begin
                res.found  = hit;
                res.slot   = pos[SLOT_W-1:0];
                res.status = STATUS_OK;
                if (hole && item.command == CMD_INSERT) begin
                    shadow_valid[pos] = 1'b1;
                    shadow_key[pos]   = item.key;
                end
            end else begin
                res.status = STATUS_FULL;
            end
        end
        return res;
    endfunction

    function automatic int unsigned draw_gap();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // mostly inserts and lookups on reused or colliding keys so chains and full tables appear
    function automatic t_in_item random_item();
        t_in_item          item;
        int unsigned       pick, size, home, mult;
        longint unsigned   wide;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            item.command = CMD_CLEAR;
        end else if (pick < 4) begin
            item.command = CMD_UNUSED;
        end else if (pick < 52) begin
            item.command = CMD_INSERT;
        end else begin
            item.command = CMD_LOOKUP;
        end
        pick = $urandom_range(0, 9);
        if (pick < 4 && key_pool.size() != 0) begin
            item.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else if (pick < 7) begin
            size = usable_size(shadow_size);
            home = $urandom_range(0, size - 1);
            mult = $urandom_range(0, 32'h7FFF_FFFF / size);
            wide = longint'(mult) * size + home;
            item.key = (wide > KEY_TOP) ? KEY_W'(home) : KEY_W'(wide);
        end else begin
            item.key = KEY_W'($urandom());
        end
        if (item.command == CMD_INSERT) begin
            key_pool.push_back(item.key);
            if (key_pool.size() > 48) begin
                void'(key_pool.pop_front());
            end
        end
        return item;
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        error_count++;
    endtask

    // presents one item and records its expected result once the transfer happens
    task automatic send_item(input t_in_item item, input bit typed, input t_out_item typed_res);
        int unsigned gap;
        t_pending    entry;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        entry.seq = items_sent;
        entry.res = hash_set_predict(item);
        case (item.command)
            CMD_CLEAR:  n_clear++;
            CMD_INSERT: n_insert++;
            CMD_LOOKUP: n_lookup++;
            default:    n_other++;
        endcase
        if (entry.res.found) begin
            n_hit++;
        end
        if (entry.res.status == STATUS_FULL) begin
            n_full++;
        end
        if (typed) begin
            entry.res = typed_res;
        end
        result_q.push_back(entry);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] value);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        shadow_size = value;
        n_sizes++;
    endtask

    initial begin : result_check
        int unsigned hold;
        t_pending    want;
        forever begin
            hold = draw_gap();
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            n_results++;
            if (result_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0d slot=%0d status=%0d",
                    o_out_data.found, o_out_data.slot, o_out_data.status));
            end else begin
                want = result_q.pop_front();
                if (o_out_data.found !== want.res.found) begin
                    report_mismatch($sformatf("item %0d found got %0d want %0d",
                        want.seq, o_out_data.found, want.res.found));
                end
                if (o_out_data.slot !== want.res.slot) begin
                    report_mismatch($sformatf("item %0d slot got %0d want %0d",
                        want.seq, o_out_data.slot, want.res.slot));
                end
                if (o_out_data.status !== want.res.status) begin
                    report_mismatch($sformatf("item %0d status got %0d want %0d",
                        want.seq, o_out_data.status, want.res.status));
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
            result_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        t_in_item    item;
        t_out_item   typed_res;
        int unsigned phase_len, pick;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_SIZE) begin
                drain();
                write_size(CFG_W'(DIRECTED[r].value));
            end else begin
                item.command     = DIRECTED[r].command;
                item.key         = DIRECTED[r].value;
                typed_res.found  = DIRECTED[r].found;
                typed_res.slot   = DIRECTED[r].slot;
                typed_res.status = DIRECTED[r].status;
                send_item(item, DIRECTED[r].typed, typed_res);
            end
        end

        // random phases, each under one table size
        while (items_sent < $size(DIRECTED) + RANDOM_ITEMS) begin
            drain();
            pick = $urandom_range(0, 15);
            case (pick)
                7:       write_size(CFG_W'(4093));
                8:       write_size(CFG_W'(TABLE_DEPTH));
                9:       write_size('0);
                10:      write_size(CFG_W'(1));
                11:      write_size('1);
                12:      write_size(CFG_W'($urandom_range(2, 35)));
                13:      write_size(CFG_W'($urandom_range(13, TABLE_DEPTH)));
                14:      write_size(CFG_W'($urandom()));
                default: begin
                    case ($urandom_range(0, 5))
                        0:       write_size(CFG_W'(13));
                        1:       write_size(CFG_W'(17));
                        2:       write_size(CFG_W'(23));
                        3:       write_size(CFG_W'(31));
                        4:       write_size(CFG_W'(37));
                        default: write_size(CFG_W'(43));
                    endcase
                end
            endcase
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0) begin
                item = '0;
                send_item(item, 1'b0, '0);
            end
            phase_len = $urandom_range(20, 60);
            repeat (phase_len) begin
                send_item(random_item(), 1'b0, '0);
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        $display("covered %0d items: %0d inserts, %0d lookups, %0d clears, %0d unused commands",
            items_sent, n_insert, n_lookup, n_clear, n_other);
        $display("%0d results seen, %0d hits, %0d full-table walks, %0d size writes, %0d errors",
            n_results, n_hit, n_full, n_sizes, error_count);
        if (error_count == 0 && result_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/dhks_pkg.sv
rtl/dhks_store.sv
rtl/double_hash_key_set_top.sv
sim/tb_double_hash_key_set_top.sv
